// File: rtl/core/buzzer_beep_pattern_generator_top_assert.svh
// Assertion helpers shared by the buzzer pattern RTL.
`ifndef BUZZER_BEEP_PATTERN_GENERATOR_TOP_ASSERT_SVH
`define BUZZER_BEEP_PATTERN_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BBPG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbpg assertion failed");

// Next-cycle implication, disabled during reset.
`define BBPG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbpg assertion failed");

`endif

// File: rtl/core/bbpg_pkg.sv
package bbpg_pkg;

   // Phase counter width; stored lengths follow it.
   localparam int TIME_WIDTH = 16;
   // Width of the on/off tick fields on the ports.
   localparam int TICKS_W = 16;

   localparam logic [TIME_WIDTH-1:0] PHASE_MAX  = '1;
   localparam logic [7:0]            CONT_BEEPS = 8'hFF;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_CLEAR = 2'd2
   } bbpg_kind_type;

   typedef struct packed {
      bbpg_kind_type      kind;
      logic               continuous;
      logic [7:0]         priority_req;
      logic [7:0]         beep_count;
      logic [TICKS_W-1:0] on_ticks;
      logic [TICKS_W-1:0] off_ticks;
   } bbpg_req_type;

   typedef struct packed {
      logic       buzzer_on;
      logic [7:0] beeps_left;
      logic       accepted;
   } bbpg_rsp_type;

   // Saturate a port length into the phase counter range.
   function automatic logic [TIME_WIDTH-1:0] clamp_len(input logic [TICKS_W-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      if (wide > 64'(PHASE_MAX)) begin
         clamp_len = PHASE_MAX;
      end else begin
         clamp_len = TIME_WIDTH'(v);
      end
   endfunction

endpackage

// File: rtl/core/bbpg_in_stage.sv
module bbpg_in_stage
   import bbpg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  bbpg_req_type req_data,
   input  logic         advance,
   output logic         item_valid,
   output bbpg_req_type item_data
);

   logic         valid_ff;
   logic         valid_in;
   bbpg_req_type data_ff;
   logic         take;

   assign req_stall = valid_ff & ~advance;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

// File: rtl/core/bbpg_engine.sv
`include "buzzer_beep_pattern_generator_top_assert.svh"

module bbpg_engine
   import bbpg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  bbpg_req_type item,
   output bbpg_rsp_type result
);

   logic                  mode_ff,      mode_in;
   logic [7:0]            prio_ff,      prio_in;
   logic [7:0]            remaining_ff, remaining_in;
   logic                  sounding_ff,  sounding_in;
   logic [TIME_WIDTH-1:0] on_len_ff,    on_len_in;
   logic [TIME_WIDTH-1:0] off_len_ff,   off_len_in;
   logic [TIME_WIDTH-1:0] phase_ff,     phase_in;
   logic [TIME_WIDTH-1:0] phase_inc;
   logic                  snd_mid;
   logic [TIME_WIDTH-1:0] ph_mid;
   logic                  win;
   logic                  acc;

   assign phase_inc = (phase_ff == PHASE_MAX) ? phase_ff : phase_ff + 1'b1;
   assign win = (item.priority_req > prio_ff) || (remaining_ff == 8'd0);

   always_comb begin
      mode_in      = mode_ff;
      prio_in      = prio_ff;
      remaining_in = remaining_ff;
      sounding_in  = sounding_ff;
      on_len_in    = on_len_ff;
      off_len_in   = off_len_ff;
      phase_in     = phase_ff;
      snd_mid      = sounding_ff;
      ph_mid       = phase_inc;
      acc          = 1'b0;
      unique case (item.kind)
         KIND_TICK: begin
            // on phase ends first, then a new beep may start in the same tick
            if (sounding_ff && (phase_inc >= on_len_ff)) begin
               snd_mid = 1'b0;
               ph_mid  = '0;
            end
            sounding_in = snd_mid;
            phase_in    = ph_mid;
            if (!snd_mid && (ph_mid >= off_len_ff) &&
                (mode_ff || (remaining_ff != 8'd0))) begin
               sounding_in = 1'b1;
               phase_in    = '0;
               if (!mode_ff) begin
                  remaining_in = remaining_ff - 8'd1;
               end
            end
         end
         KIND_START: begin
            if (win) begin
               acc        = 1'b1;
               mode_in    = item.continuous;
               prio_in    = item.priority_req;
               on_len_in  = clamp_len(item.on_ticks);
               off_len_in = clamp_len(item.off_ticks);
               if (item.continuous) begin
                  remaining_in = CONT_BEEPS;
                  sounding_in  = 1'b0;
                  phase_in     = PHASE_MAX;
               end else if (item.beep_count != 8'd0) begin
                  remaining_in = item.beep_count - 8'd1;
                  sounding_in  = 1'b1;
                  phase_in     = '0;
               end else begin
                  remaining_in = 8'd0;
                  sounding_in  = 1'b0;
                  phase_in     = '0;
               end
            end
         end
         KIND_CLEAR: begin
            mode_in      = 1'b0;
            remaining_in = 8'd0;
            sounding_in  = 1'b0;
            on_len_in    = '0;
            off_len_in   = '0;
            phase_in     = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         prio_ff      <= 8'd0;
         remaining_ff <= 8'd0;
         sounding_ff  <= 1'b0;
         on_len_ff    <= '0;
         off_len_ff   <= '0;
         phase_ff     <= '0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         prio_ff      <= prio_in;
         remaining_ff <= remaining_in;
         sounding_ff  <= sounding_in;
         on_len_ff    <= on_len_in;
         off_len_ff   <= off_len_in;
         phase_ff     <= phase_in;
      end
   end

   assign result.buzzer_on  = sounding_in;
   assign result.beeps_left = remaining_in;
   assign result.accepted   = acc;

   `BBPG_ASSERT_NOW(a_cont_full, clock, reset, mode_ff, remaining_ff == CONT_BEEPS)
   `BBPG_ASSERT_NEXT(a_clear_silent, clock, reset, fire && (item.kind == KIND_CLEAR),
      !sounding_ff && (remaining_ff == 8'd0))
   `BBPG_ASSERT_NOW(a_acc_start, clock, reset, acc, item.kind == KIND_START)

endmodule

// File: rtl/core/bbpg_out_stage.sv
module bbpg_out_stage
   import bbpg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  bbpg_rsp_type result,
   output logic         advance,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output bbpg_rsp_type rsp_data
);

   logic         valid_ff;
   bbpg_rsp_type data_ff;

   assign advance = ~valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_valid) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: rtl/core/buzzer_beep_pattern_generator_top.sv
// Buzzer beep pattern timer. Each request beat is one tick, one start request
// or one clear, and yields exactly one response beat showing the buzzer level,
// the beeps still to start (255 in continuous mode) and whether a start request
// took over. A start wins when its priority beats the held one or when no beeps
// are pending; a counted start sounds at once, a continuous one begins on the
// next tick. Timing: a beat is registered on entry, evaluated against the
// pattern state while it is held in the input register and then lands in the
// response register, so one beat can be taken every cycle. Throughput drops
// only while the response register is full and stalled. The phase counter
// width follows TIME_WIDTH in bbpg_pkg; longer on/off lengths saturate to it.
`include "buzzer_beep_pattern_generator_top_assert.svh"

module buzzer_beep_pattern_generator_top
   import bbpg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_req_type,
   input  logic               req_continuous,
   input  logic [7:0]         req_priority_req,
   input  logic [7:0]         req_beep_count,
   input  logic [TICKS_W-1:0] req_on_ticks,
   input  logic [TICKS_W-1:0] req_off_ticks,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_buzzer_on,
   output logic [7:0]         rsp_beeps_left,
   output logic               rsp_accepted
);

   bbpg_req_type req_data;
   bbpg_req_type item_data;
   bbpg_rsp_type result;
   bbpg_rsp_type rsp_data;
   logic         item_valid;
   logic         advance;
   logic         fire;

   // code 3 maps to no enum member and falls to the do-nothing arm
   assign req_data.kind         = bbpg_kind_type'(req_req_type);
   assign req_data.continuous   = req_continuous;
   assign req_data.priority_req = req_priority_req;
   assign req_data.beep_count   = req_beep_count;
   assign req_data.on_ticks     = req_on_ticks;
   assign req_data.off_ticks    = req_off_ticks;

   bbpg_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   // state commits only when the beat moves into the response register
   assign fire = item_valid & advance;

   bbpg_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_data),
      .result (result)
   );

   bbpg_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_buzzer_on  = rsp_data.buzzer_on;
   assign rsp_beeps_left = rsp_data.beeps_left;
   assign rsp_accepted   = rsp_data.accepted;

   // back-pressure only when both stages hold a beat
   `BBPG_ASSERT_NOW(a_stall_full, clock, reset, req_stall,
      item_valid && rsp_valid && rsp_stall)

endmodule
